/* hw/rtl/prv3_pkg.sv */
package prv3_pkg;

  // field widths of the item ports
  localparam int COORD_WIDTH = 24;
  localparam int ANGLE_WIDTH = 16;

  // guard fraction bits kept below the coordinate lsb during rotation
  localparam int GUARD_BITS = 8;
  // working width: coordinate, guard bits and headroom for cordic growth
  localparam int WORK_WIDTH = COORD_WIDTH + GUARD_BITS + 2;
  // angle arithmetic runs on a 32 bit turn
  localparam int TURN_WIDTH = 32;
  localparam int MAX_STAGES = 24;

  // gain compensation, unsigned q0.32
  localparam logic [63:0] K_BASE_Q32 = 64'd2608131496;
  localparam logic [63:0] K_CORR_Q32 = 64'd1738754331;

  typedef struct packed {
    logic                          plane_select;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic        [ANGLE_WIDTH-1:0] turn_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
  } out_item_t;

  // data moving down the rotation chain
  typedef struct packed {
    logic                          plane_sel;
    logic signed [COORD_WIDTH-1:0] keep;
    logic signed [WORK_WIDTH-1:0]  a;
    logic signed [WORK_WIDTH-1:0]  b;
    logic signed [TURN_WIDTH-1:0]  z;
  } cord_t;

  // atan(2^-i) in 2^32 units per turn
  function automatic logic [TURN_WIDTH-1:0] atan_turn32(input int idx);
    logic [TURN_WIDTH-1:0] t;
    case (idx)
      0:  t = 32'd536870912;
      1:  t = 32'd316933406;
      2:  t = 32'd167458907;
      3:  t = 32'd85004756;
      4:  t = 32'd42667331;
      5:  t = 32'd21354465;
      6:  t = 32'd10680862;
      7:  t = 32'd5340245;
      8:  t = 32'd2670163;
      9:  t = 32'd1335087;
      10: t = 32'd667544;
      11: t = 32'd333772;
      12: t = 32'd166886;
      13: t = 32'd83443;
      14: t = 32'd41722;
      15: t = 32'd20861;
      16: t = 32'd10430;
      17: t = 32'd5215;
      18: t = 32'd2608;
      19: t = 32'd1304;
      20: t = 32'd652;
      21: t = 32'd326;
      22: t = 32'd163;
      23: t = 32'd81;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

/* hw/rtl/prv3_gain.sv */
module prv3_gain #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  prv3_pkg::in_item_t item_i,
  output logic               valid_o,
  output prv3_pkg::cord_t    cord_o
);

  localparam int CW = prv3_pkg::COORD_WIDTH;
  localparam int AW = prv3_pkg::ANGLE_WIDTH;
  localparam int WW = prv3_pkg::WORK_WIDTH;
  localparam int TW = prv3_pkg::TURN_WIDTH;
  localparam int PW = CW + 33;
  localparam int SHIFT = TW - prv3_pkg::GUARD_BITS;
  localparam logic [63:0] GAIN_WIDE =
    prv3_pkg::K_BASE_Q32 + (prv3_pkg::K_CORR_Q32 >> (2 * ROTATION_STAGES));
  localparam logic [31:0] GAIN_K = GAIN_WIDE[31:0];

  // multiply stage
  logic                   valid1_q;
  logic signed [PW-1:0]   prod_a_q, prod_a_d;
  logic signed [PW-1:0]   prod_b_q, prod_b_d;
  logic signed [CW-1:0]   keep1_q, keep1_d;
  logic                   plane1_q;
  logic [AW-1:0]          turn1_q;

  // round, fold and angle stage
  logic                   valid2_q;
  prv3_pkg::cord_t        cord2_q, cord2_d;

  logic signed [CW-1:0]   sel_a;
  logic signed [PW-1:0]   gain_s;
  logic signed [PW-1:0]   rnd_a, rnd_b;
  logic signed [WW-1:0]   sc_a, sc_b;
  logic                   fold;

  always_comb begin
    sel_a    = item_i.plane_select ? item_i.vec_y : item_i.vec_x;
    keep1_d  = item_i.plane_select ? item_i.vec_x : item_i.vec_y;
    gain_s   = $signed(PW'({1'b0, GAIN_K}));
    prod_a_d = PW'(sel_a) * gain_s;
    prod_b_d = PW'(item_i.vec_z) * gain_s;
  end

  always_comb begin
    rnd_a = prod_a_q + $signed(PW'(1) <<< (SHIFT - 1));
    rnd_b = prod_b_q + $signed(PW'(1) <<< (SHIFT - 1));
    sc_a  = WW'($signed(rnd_a[PW-1:SHIFT]));
    sc_b  = WW'($signed(rnd_b[PW-1:SHIFT]));
    // second or third quarter: negate and turn by half
    fold  = turn1_q[AW-1] ^ turn1_q[AW-2];
    cord2_d.plane_sel = plane1_q;
    cord2_d.keep      = keep1_q;
    cord2_d.a         = fold ? -sc_a : sc_a;
    cord2_d.b         = fold ? -sc_b : sc_b;
    cord2_d.z         = $signed({turn1_q[AW-1] ^ fold, turn1_q[AW-2:0], (TW - AW)'(0)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_a_q <= prod_a_d;
    prod_b_q <= prod_b_d;
    keep1_q  <= keep1_d;
    plane1_q <= item_i.plane_select;
    turn1_q  <= item_i.turn_angle;
    cord2_q  <= cord2_d;
  end

  assign valid_o = valid2_q;
  assign cord_o  = cord2_q;

endmodule

/* hw/rtl/prv3_cell.sv */
module prv3_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  prv3_pkg::cord_t cord_i,
  output logic            valid_o,
  output prv3_pkg::cord_t cord_o
);

  localparam int WW = prv3_pkg::WORK_WIDTH;
  localparam int TW = prv3_pkg::TURN_WIDTH;
  localparam logic [TW-1:0] ATAN = prv3_pkg::atan_turn32(STAGE_IDX);

  logic                 valid_q;
  prv3_pkg::cord_t      cord_q, cord_d;
  logic signed [WW-1:0] a_s, b_s, da, db;
  logic signed [TW-1:0] z_s;

  always_comb begin
    a_s    = cord_i.a;
    b_s    = cord_i.b;
    z_s    = cord_i.z;
    da     = b_s >>> STAGE_IDX;
    db     = a_s >>> STAGE_IDX;
    cord_d = cord_i;
    // residual angle non-negative: turn forward
    if (!z_s[TW-1]) begin
      cord_d.a = a_s - da;
      cord_d.b = b_s + db;
      cord_d.z = z_s - $signed(ATAN);
    end else begin
      cord_d.a = a_s + da;
      cord_d.b = b_s - db;
      cord_d.z = z_s + $signed(ATAN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    cord_q <= cord_d;
  end

  assign valid_o = valid_q;
  assign cord_o  = cord_q;

endmodule

/* hw/rtl/plane_rotate_vector3_core.sv */
// plane_rotate_vector3_core: rotates a 3d vector by a binary angle in the
// x-z plane (plane_select 0, y kept) or the y-z plane (plane_select 1, x kept)
// using a gain-compensated cordic rotation
//
// input channel: an item is taken on a rising edge with start_i high and
// busy_o low; busy_o is always low, so one item may be started every cycle
// output channel: done_o is high for exactly one cycle with the rotated item
// on result_o; the receiver must take it in that cycle, there is no stall
//
// latency: ROTATION_STAGES + 3 cycles from the accepting edge to the edge that
// takes the result (19 at the default), throughput one item per cycle; set by
// the gain multiply stage, the fold stage, one cell per cordic stage and the
// rounding/saturating output register
//
// reset: all valid flags in the pipe clear, so no result appears until new
// items are started; items in flight at reset are dropped
module plane_rotate_vector3_core #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  prv3_pkg::in_item_t  item_i,
  output logic                done_o,
  output prv3_pkg::out_item_t result_o
);

  localparam int CW = prv3_pkg::COORD_WIDTH;
  localparam int WW = prv3_pkg::WORK_WIDTH;
  localparam int GB = prv3_pkg::GUARD_BITS;
  localparam int RW = WW - GB;

  // round away the guard bits and clamp to the coordinate range
  function automatic logic signed [CW-1:0] round_sat(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] s;
    logic signed [RW-1:0] r;
    logic signed [CW-1:0] o;
    s = v + $signed(WW'(1) <<< (GB - 1));
    r = s[WW-1:GB];
    if (r[RW-1:CW-1] == '0 || r[RW-1:CW-1] == '1) begin
      o = r[CW-1:0];
    end else if (r[RW-1]) begin
      o = {1'b1, (CW - 1)'(0)};
    end else begin
      o = {1'b0, {(CW - 1){1'b1}}};
    end
    return o;
  endfunction

  // the pipe never holds off a new item
  assign busy_o = 1'b0;

  logic                accept;
  logic                valid_c [0:ROTATION_STAGES];
  prv3_pkg::cord_t     cord_c  [0:ROTATION_STAGES];

  assign accept = start_i & ~busy_o;

  // gain compensation and quarter fold ahead of the chain
  prv3_gain #(
    .ROTATION_STAGES(ROTATION_STAGES)
  ) u_gain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .item_i (item_i),
    .valid_o(valid_c[0]),
    .cord_o (cord_c[0])
  );

  // one cordic micro-rotation per cell, passed on every cycle
  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_cell
    prv3_cell #(
      .STAGE_IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(valid_c[g]),
      .cord_i (cord_c[g]),
      .valid_o(valid_c[g+1]),
      .cord_o (cord_c[g+1])
    );
  end

  // output register: round, saturate and put the coordinates back in place
  logic                done_q;
  prv3_pkg::out_item_t res_q, res_d;
  prv3_pkg::cord_t     last;
  logic signed [CW-1:0] ra, rb;

  always_comb begin
    last = cord_c[ROTATION_STAGES];
    ra   = round_sat(last.a);
    rb   = round_sat(last.b);
    res_d.rot_z = rb;
    if (last.plane_sel) begin
      res_d.rot_x = last.keep;
      res_d.rot_y = ra;
    end else begin
      res_d.rot_x = ra;
      res_d.rot_y = last.keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_c[ROTATION_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
